// ----- design/ttb_pkg.sv -----
// shared widths, constants and helpers for the triangle tangent/bitangent block
`default_nettype none
package ttb_pkg;
    localparam int FIELD_W      = 16;
    localparam int DELTA_W      = 17;
    localparam int PROD_W       = 2 * DELTA_W;
    localparam int NUM_W        = PROD_W + 1;
    localparam int FRAC_SHIFT   = 20;
    localparam int QUOT_BITS    = 31;
    localparam int RES_W        = QUOT_BITS + 1;
    localparam int HEAD_SHIFT   = QUOT_BITS - FRAC_SHIFT;
    localparam int FRONT_STAGES = 3;
    localparam int DIV_STAGES   = QUOT_BITS + 1;
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES;

    localparam logic [RES_W-1:0] SAT_POS = {1'b0, {QUOT_BITS{1'b1}}};
    localparam logic [RES_W-1:0] SAT_NEG = {1'b1, {QUOT_BITS{1'b0}}};

    function automatic logic signed [DELTA_W-1:0] field_diff(
        input logic [FIELD_W-1:0] from_v,
        input logic [FIELD_W-1:0] to_v
    );
        field_diff = $signed({to_v[FIELD_W-1], to_v}) - $signed({from_v[FIELD_W-1], from_v});
    endfunction

    function automatic logic signed [NUM_W-1:0] prod_diff(
        input logic signed [PROD_W-1:0] a,
        input logic signed [PROD_W-1:0] b
    );
        prod_diff = $signed({a[PROD_W-1], a}) - $signed({b[PROD_W-1], b});
    endfunction
endpackage
`default_nettype wire

// ----- design/triangle_tangent_bitangent_top.sv -----
// triangle tangent/bitangent unit: uv-space edge solve with pipelined division
//
// input channel: one triangle per transaction (pos_a/b/c, uv_a/b/c) on
// in_valid/in_ready. output channel: tangent, bitangent (signed q12.20,
// truncated toward zero, saturated) and degenerate on out_valid/out_ready.
// a result passes through 36 register stages that start at the accepting edge:
// 3 for edges, products and determinant, 32 for the six parallel
// restoring dividers (a setup stage, then one quotient bit per stage),
// 1 for the output register. throughput is one triangle per cycle unless
// the output stalls; the dividers are fully pipelined.
// a zero uv determinant gives zero vectors with degenerate set.
// reset clears all valid bits; payload registers are not reset.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; it advances whenever out_valid is low or out_ready is high.
`default_nettype none
module triangle_tangent_bitangent_top
    import ttb_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [3*FIELD_W-1:0] pos_a,
    input  wire logic [3*FIELD_W-1:0] pos_b,
    input  wire logic [3*FIELD_W-1:0] pos_c,
    input  wire logic [2*FIELD_W-1:0] uv_a,
    input  wire logic [2*FIELD_W-1:0] uv_b,
    input  wire logic [2*FIELD_W-1:0] uv_c,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [RES_W-1:0]  tan_x,
    output logic signed [RES_W-1:0]  tan_y,
    output logic signed [RES_W-1:0]  tan_z,
    output logic signed [RES_W-1:0]  bitan_x,
    output logic signed [RES_W-1:0]  bitan_y,
    output logic signed [RES_W-1:0]  bitan_z,
    output logic                     degenerate
);
    logic                     en;
    logic [PIPE_STAGES-1:0]   valid_reg;
    logic [DIV_STAGES-1:0]    degen_reg;
    logic                     out_valid_reg;
    logic                     degen_out_reg;
    logic [RES_W-1:0]         tan_reg   [3];
    logic [RES_W-1:0]         bitan_reg [3];

    logic signed [NUM_W-1:0]  tn [3];
    logic signed [NUM_W-1:0]  bn [3];
    logic signed [NUM_W-1:0]  det;
    logic                     det_zero;
    logic [RES_W-1:0]         tq [3];
    logic [RES_W-1:0]         bq [3];

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    ttb_front u_front (
        .clk      (clk),
        .en       (en),
        .pos_a    (pos_a),
        .pos_b    (pos_b),
        .pos_c    (pos_c),
        .uv_a     (uv_a),
        .uv_b     (uv_b),
        .uv_c     (uv_c),
        .tn       (tn),
        .bn       (bn),
        .det      (det),
        .det_zero (det_zero)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        ttb_div u_div_t (
            .clk  (clk),
            .en   (en),
            .num  (tn[k]),
            .den  (det),
            .quot (tq[k])
        );
        ttb_div u_div_b (
            .clk  (clk),
            .en   (en),
            .num  (bn[k]),
            .den  (det),
            .quot (bq[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[PIPE_STAGES-2:0], in_valid};
            out_valid_reg <= valid_reg[PIPE_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            degen_reg     <= {degen_reg[DIV_STAGES-2:0], det_zero};
            degen_out_reg <= degen_reg[DIV_STAGES-1];
            for (int k = 0; k < 3; k++)
            begin
                tan_reg[k]   <= degen_reg[DIV_STAGES-1] ? '0 : tq[k];
                bitan_reg[k] <= degen_reg[DIV_STAGES-1] ? '0 : bq[k];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign degenerate = degen_out_reg;
    assign tan_x      = tan_reg[0];
    assign tan_y      = tan_reg[1];
    assign tan_z      = tan_reg[2];
    assign bitan_x    = bitan_reg[0];
    assign bitan_y    = bitan_reg[1];
    assign bitan_z    = bitan_reg[2];

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> tan_x == 0 && tan_y == 0 && tan_z == 0
            && bitan_x == 0 && bitan_y == 0 && bitan_z == 0)
        else $error("degenerate transaction with nonzero vectors");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(valid_reg))
        else $error("pipeline moved while output stalled");

    a_feed: assert property (@(posedge clk) disable iff (!rst_n)
        en && valid_reg[PIPE_STAGES-1] |=> out_valid)
        else $error("result lost at output register");
endmodule
`default_nettype wire

// ----- design/ttb_front.sv -----
// edge and uv delta stage, product stage and numerator/determinant stage
`default_nettype none
module ttb_front
    import ttb_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [3*FIELD_W-1:0]    pos_a,
    input  wire logic [3*FIELD_W-1:0]    pos_b,
    input  wire logic [3*FIELD_W-1:0]    pos_c,
    input  wire logic [2*FIELD_W-1:0]    uv_a,
    input  wire logic [2*FIELD_W-1:0]    uv_b,
    input  wire logic [2*FIELD_W-1:0]    uv_c,
    output logic signed [NUM_W-1:0]      tn [3],
    output logic signed [NUM_W-1:0]      bn [3],
    output logic signed [NUM_W-1:0]      det,
    output logic                         det_zero
);
    logic signed [DELTA_W-1:0] e1_reg [3];
    logic signed [DELTA_W-1:0] e2_reg [3];
    logic signed [DELTA_W-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [PROD_W-1:0]  pt1_reg [3];
    logic signed [PROD_W-1:0]  pt2_reg [3];
    logic signed [PROD_W-1:0]  pb1_reg [3];
    logic signed [PROD_W-1:0]  pb2_reg [3];
    logic signed [PROD_W-1:0]  pd1_reg, pd2_reg;
    logic signed [NUM_W-1:0]   tn_reg [3];
    logic signed [NUM_W-1:0]   bn_reg [3];
    logic signed [NUM_W-1:0]   det_reg;
    logic signed [NUM_W-1:0]   det_next;
    logic                      det_zero_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k] <= field_diff(pos_a[k*FIELD_W +: FIELD_W], pos_b[k*FIELD_W +: FIELD_W]);
                e2_reg[k] <= field_diff(pos_a[k*FIELD_W +: FIELD_W], pos_c[k*FIELD_W +: FIELD_W]);
            end
            du1_reg <= field_diff(uv_a[FIELD_W-1:0], uv_b[FIELD_W-1:0]);
            dv1_reg <= field_diff(uv_a[2*FIELD_W-1:FIELD_W], uv_b[2*FIELD_W-1:FIELD_W]);
            du2_reg <= field_diff(uv_a[FIELD_W-1:0], uv_c[FIELD_W-1:0]);
            dv2_reg <= field_diff(uv_a[2*FIELD_W-1:FIELD_W], uv_c[2*FIELD_W-1:FIELD_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pt1_reg[k] <= dv2_reg * e1_reg[k];
                pt2_reg[k] <= dv1_reg * e2_reg[k];
                pb1_reg[k] <= du1_reg * e2_reg[k];
                pb2_reg[k] <= du2_reg * e1_reg[k];
            end
            pd1_reg <= du1_reg * dv2_reg;
            pd2_reg <= du2_reg * dv1_reg;
        end
    end

    assign det_next = prod_diff(pd1_reg, pd2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                tn_reg[k] <= prod_diff(pt1_reg[k], pt2_reg[k]);
                bn_reg[k] <= prod_diff(pb1_reg[k], pb2_reg[k]);
            end
            det_reg      <= det_next;
            det_zero_reg <= (det_next == '0);
        end
    end

    assign tn       = tn_reg;
    assign bn       = bn_reg;
    assign det      = det_reg;
    assign det_zero = det_zero_reg;
endmodule
`default_nettype wire

// ----- design/ttb_div.sv -----
// pipelined restoring divider, setup stage then one quotient bit per stage, saturated q12.20 result
`default_nettype none
module ttb_div
    import ttb_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic signed [NUM_W-1:0] den,
    output logic [RES_W-1:0]             quot
);
    logic [NUM_W-1:0]     d_reg    [DIV_STAGES];
    logic [NUM_W-1:0]     r_reg    [DIV_STAGES];
    logic [QUOT_BITS-1:0] tail_reg [DIV_STAGES];
    logic [QUOT_BITS-1:0] q_reg    [DIV_STAGES];
    logic                 neg_reg  [DIV_STAGES];
    logic                 ovf_reg  [DIV_STAGES];

    logic [NUM_W-1:0]     n_mag;
    logic [NUM_W-1:0]     d_mag;
    logic [QUOT_BITS-1:0] q_last;

    assign n_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign d_mag = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0]    <= d_mag;
            r_reg[0]    <= NUM_W'(n_mag >> HEAD_SHIFT);
            tail_reg[0] <= {n_mag[HEAD_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};
            q_reg[0]    <= '0;
            neg_reg[0]  <= num[NUM_W-1] ^ den[NUM_W-1];
            ovf_reg[0]  <= ({{HEAD_SHIFT{1'b0}}, n_mag} >= {d_mag, {HEAD_SHIFT{1'b0}}});
        end
    end

    for (genvar k = 0; k < QUOT_BITS; k++)
    begin : g_step
        logic [NUM_W:0] trial;
        logic [NUM_W:0] diff;
        logic           take;

        assign trial = {r_reg[k], tail_reg[k][QUOT_BITS-1]};
        assign diff  = trial - {1'b0, d_reg[k]};
        assign take  = (trial >= {1'b0, d_reg[k]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k+1]    <= d_reg[k];
                r_reg[k+1]    <= take ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
                tail_reg[k+1] <= {tail_reg[k][QUOT_BITS-2:0], 1'b0};
                q_reg[k+1]    <= {q_reg[k][QUOT_BITS-2:0], take};
                neg_reg[k+1]  <= neg_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
            end
        end
    end

    assign q_last = q_reg[DIV_STAGES-1];

    always_comb
    begin
        if (ovf_reg[DIV_STAGES-1])
            quot = neg_reg[DIV_STAGES-1] ? SAT_NEG : SAT_POS;
        else if (neg_reg[DIV_STAGES-1])
            quot = RES_W'(-{1'b0, q_last});
        else
            quot = {1'b0, q_last};
    end
endmodule
`default_nettype wire

// ----- bench/ttb_checker.sv -----
// checker for the triangle tangent/bitangent unit: predicts each result and compares it
`timescale 1ns / 1ps
module ttb_checker
    import ttb_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_ready,
    input  wire logic [3*FIELD_W-1:0]     pos_a,
    input  wire logic [3*FIELD_W-1:0]     pos_b,
    input  wire logic [3*FIELD_W-1:0]     pos_c,
    input  wire logic [2*FIELD_W-1:0]     uv_a,
    input  wire logic [2*FIELD_W-1:0]     uv_b,
    input  wire logic [2*FIELD_W-1:0]     uv_c,
    input  wire logic                     out_valid,
    input  wire logic                     out_ready,
    input  wire logic signed [RES_W-1:0]  tan_x,
    input  wire logic signed [RES_W-1:0]  tan_y,
    input  wire logic signed [RES_W-1:0]  tan_z,
    input  wire logic signed [RES_W-1:0]  bitan_x,
    input  wire logic signed [RES_W-1:0]  bitan_y,
    input  wire logic signed [RES_W-1:0]  bitan_z,
    input  wire logic                     degenerate,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic [RES_W-1:0] tx, ty, tz, bx, by, bz;
        logic             degen;
    } frame_t;

    frame_t tangent_q[$];

    function automatic longint sx16(logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic logic [RES_W-1:0] q16_div(longint num, longint den);
        longint unsigned n, d, q;
        logic neg;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        neg = (num < 0) != (den < 0);
        q = (n << 20) / d;
        if (neg)
        begin
            if (q >= 64'h8000_0000)
                return SAT_NEG;
            return RES_W'(-q);
        end
        if (q > 64'h7FFF_FFFF)
            return SAT_POS;
        return RES_W'(q);
    endfunction

    function automatic frame_t solve_triangle(logic [47:0] pa, logic [47:0] pb,
                                              logic [47:0] pc, logic [31:0] ua,
                                              logic [31:0] ub, logic [31:0] uc);
        frame_t f;
        longint e1[3], e2[3];
        longint du1, dv1, du2, dv2, det;
        logic [RES_W-1:0] tv[3], bv[3];
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = sx16(pb[16*k +: 16]) - sx16(pa[16*k +: 16]);
            e2[k] = sx16(pc[16*k +: 16]) - sx16(pa[16*k +: 16]);
        end
        du1 = sx16(ub[15:0]) - sx16(ua[15:0]);
        dv1 = sx16(ub[31:16]) - sx16(ua[31:16]);
        du2 = sx16(uc[15:0]) - sx16(ua[15:0]);
        dv2 = sx16(uc[31:16]) - sx16(ua[31:16]);
        det = du1 * dv2 - du2 * dv1;
        f = '0;
        if (det == 0)
        begin
            f.degen = 1'b1;
            return f;
        end
        for (int k = 0; k < 3; k++)
        begin
            tv[k] = q16_div(dv2 * e1[k] - dv1 * e2[k], det);
            bv[k] = q16_div(du1 * e2[k] - du2 * e1[k], det);
        end
        f.tx = tv[0]; f.ty = tv[1]; f.tz = tv[2];
        f.bx = bv[0]; f.by = bv[1]; f.bz = bv[2];
        return f;
    endfunction

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        frame_t got, want;
        if (rst_n && in_valid && in_ready)
            tangent_q = {tangent_q, solve_triangle(pos_a, pos_b, pos_c, uv_a, uv_b, uv_c)};
        if (rst_n && out_valid && out_ready)
        begin
            got = '{tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z, degenerate};
            if (tangent_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = tangent_q.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
        pending = tangent_q.size();
    end

endmodule

// ----- bench/tb_triangle_tangent_bitangent_top.sv -----
// testbench top for the triangle tangent/bitangent unit: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_triangle_tangent_bitangent_top;
    import ttb_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic [47:0] pos_a = '0, pos_b = '0, pos_c = '0;
    logic [31:0] uv_a = '0, uv_b = '0, uv_c = '0;
    logic in_ready, out_valid, degenerate;
    logic signed [RES_W-1:0] tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z;
    int fail_count, pending;
    int send_idle_pct = 18;
    int recv_idle_pct = 56;
    logic hold_off = 1'b0;

    triangle_tangent_bitangent_top uut (.*);
    ttb_checker chk (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

    function automatic logic [15:0] rnd16();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_triangle(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                                 logic [31:0] ua, logic [31:0] ub, logic [31:0] uc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pos_a <= a; pos_b <= b; pos_c <= c;
        uv_a <= ua; uv_b <= ub; uv_c <= uc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        logic [47:0] p[3];
        logic [31:0] u[3];
        for (int i = 0; i < 3; i++)
        begin
            p[i] = {rnd16(), rnd16(), rnd16()};
            u[i] = {rnd16(), rnd16()};
        end
        // occasional collinear uvs for zero determinant
        if ($urandom_range(9) == 0)
            u[2] = u[1];
        send_triangle(p[0], p[1], p[2], u[0], u[1], u[2]);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed: extremes, degenerate, saturation both ways, small cases
        send_triangle('0, '0, '0, '0, '0, '0);
        send_triangle('0, {3{16'h0100}}, '0, '0, 32'h0000_1000, 32'h1000_0000);
        send_triangle('0, {3{16'h7FFF}}, {3{16'h8000}}, '0, 32'h0000_0001, 32'h0001_0000);
        send_triangle('0, {3{16'h8000}}, {3{16'h7FFF}}, '0, 32'h0000_0001, 32'h0001_0000);
        send_triangle({3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}},
                      32'h8000_8000, 32'h7FFF_7FFF, 32'h8000_7FFF);
        send_triangle({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}},
                      32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_8000);
        send_triangle({3{16'hFFFF}}, {3{16'h1234}}, {3{16'hEDCB}},
                      32'hFFFF_FFFF, 32'h0010_0020, 32'h0030_0060);
        send_triangle('1, '1, '1, '1, '1, '1);
        send_triangle(48'h0003_0002_0001, 48'h0006_0005_0004, 48'h0009_0008_0007,
                      32'h0000_0000, 32'h0000_0003, 32'h0007_0000);
        send_triangle(48'h0003_0002_0001, 48'hFFFA_0005_FFFC, 48'h0009_FFF8_0007,
                      32'h0001_0001, 32'hFFFD_0000, 32'h0002_FFF9);
        for (int i = 0; i < 10; i++)
            send_random();
        // receiver holds off long enough to fill the pipeline
        fork
            begin
                hold_off = 1'b1;
                repeat (120) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 60; i++)
                send_random();
        join
        for (int i = 0; i < 520; i++)
            send_random();
        send_idle_pct = 56;
        recv_idle_pct = 18;
        for (int i = 0; i < 530; i++)
            send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 520; i++)
            send_random();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
